// File: rtl/jets_pkg.sv
// Shared types, constants and codes of the Julia escape-time pixel block.
`timescale 1ns / 1ps

package jets_pkg;

   localparam int PIX_W          = 10;
   localparam int FRAC_SHIFT     = 30;
   localparam int NUM_W          = PIX_W + FRAC_SHIFT;
   localparam int MAP_BIAS_SHIFT = FRAC_SHIFT - 1;
   localparam int Z_W            = 32;
   localparam int PROD_W         = 2 * Z_W;
   localparam int ZR_SHIFT       = 28;
   localparam int ZI_SHIFT       = 27;
   localparam int ESC_BIT        = 58;
   localparam int LIMIT_W        = 8;
   localparam int COLOR_W        = 32;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int REQ_TDATA_W    = 24;
   localparam int RSP_TDATA_W    = 48;
   localparam int RSP_PAD_W      = RSP_TDATA_W - COLOR_W - 1 - LIMIT_W;
   localparam int REQ_PAD_W      = REQ_TDATA_W - 2 * PIX_W;

   localparam int DEF_IMAGE_WIDTH  = 800;
   localparam int DEF_IMAGE_HEIGHT = 600;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_C_REAL            = 3'd0,
      CSR_C_IMAG            = 3'd1,
      CSR_ITERATION_LIMIT   = 3'd2,
      CSR_FIRST_BAND_LIMIT  = 3'd3,
      CSR_SECOND_BAND_LIMIT = 3'd4,
      CSR_FIRST_COLOR       = 3'd5,
      CSR_SECOND_COLOR      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [Z_W-1:0]     c_real;
      logic [Z_W-1:0]     c_imag;
      logic [LIMIT_W-1:0] iteration_limit;
      logic [LIMIT_W-1:0] first_band_limit;
      logic [LIMIT_W-1:0] second_band_limit;
      logic [COLOR_W-1:0] first_color;
      logic [COLOR_W-1:0] second_color;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      c_real:            32'hF333_3333,
      c_imag:            32'h027E_F9DB,
      iteration_limit:   8'd100,
      first_band_limit:  8'd20,
      second_band_limit: 8'd80,
      first_color:       32'h0000_FFFF,
      second_color:      32'h66CC_FFFF
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_MULTIPLY,
      ST_EVALUATE
   } state_type;

   typedef struct packed {
      logic load;
      logic seed;
      logic mul;
      logic step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic at_limit;
      logic out_free;
   } status_type;

endpackage

// File: rtl/jets_div_lane.sv
// Reciprocal-multiply lane mapping one pixel coordinate to (p << 30) / DIVISOR.
`timescale 1ns / 1ps

module jets_div_lane import jets_pkg::*; #(
   parameter int DIVISOR = DEF_IMAGE_WIDTH
) (
   input  logic             clock,
   input  logic             load,
   input  logic [PIX_W-1:0] pixel,
   output logic [NUM_W-1:0] quotient
);

   localparam int          L_W      = $clog2(DIVISOR);
   localparam int          RCP_W    = NUM_W + 1;
   localparam int          MUL_W    = PIX_W + RCP_W;
   localparam int          SHIFT    = PIX_W + L_W;
   localparam logic [63:0] RCP_FULL = ((64'd1 << (NUM_W + L_W)) + 64'(DIVISOR) - 64'd1)
                                      / 64'(DIVISOR);
   localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];

   logic [MUL_W-1:0] prod;
   logic [NUM_W-1:0] quot_ff, quot_in;

   assign prod = {{RCP_W{1'b0}}, pixel} * {{PIX_W{1'b0}}, RCP};

   always_comb begin
      quot_in = quot_ff;
      if (load) quot_in = NUM_W'(prod >> SHIFT);
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quotient = quot_ff;

endmodule

// File: rtl/jets_ctrl.sv
// Sequencer for mapping, iteration and result hand-off of one pixel.
`timescale 1ns / 1ps

module jets_ctrl import jets_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      done;

   assign done = status.hit || status.at_limit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_SEED;
         ST_SEED:     state_in = ST_MULTIPLY;
         ST_MULTIPLY: state_in = ST_EVALUATE;
         ST_EVALUATE: begin
            if (!done) state_in = ST_MULTIPLY;
            else if (status.out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SEED:     cmd.seed     = 1'b1;
         ST_MULTIPLY: cmd.mul      = 1'b1;
         ST_EVALUATE: begin
            if (done) cmd.publish = status.out_free;
            else      cmd.step    = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/jets_dp.sv
// Datapath: coordinate dividers, complex square-and-add, escape test and result register.
`timescale 1ns / 1ps

module jets_dp import jets_pkg::*; #(
   parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [PIX_W-1:0]   pixel_column,
   input  logic [PIX_W-1:0]   pixel_row,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output status_type         status,
   output logic               rsp_valid,
   input  logic               rsp_tready,
   output logic [COLOR_W-1:0] pixel_color,
   output logic               did_escape,
   output logic [LIMIT_W-1:0] escape_index
);

   function automatic logic signed [Z_W-1:0] sat_z(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = {{(PROD_W - Z_W + 1){1'b0}}, {(Z_W - 1){1'b1}}};
      lo = {{(PROD_W - Z_W + 1){1'b1}}, {(Z_W - 1){1'b0}}};
      if (v > hi) return hi[Z_W-1:0];
      if (v < lo) return lo[Z_W-1:0];
      return v[Z_W-1:0];
   endfunction

   function automatic logic signed [Z_W-1:0] map_coord(input logic [NUM_W-1:0] q);
      logic signed [PROD_W-1:0] v;
      v = $signed({{(PROD_W - NUM_W){1'b0}}, q})
          - $signed(PROD_W'(1) << MAP_BIAS_SHIFT);
      return sat_z(v);
   endfunction

   logic [NUM_W-1:0]         quot_col, quot_row;
   logic signed [Z_W-1:0]    zr_ff, zr_in, zi_ff, zi_in;
   logic signed [PROD_W-1:0] rr_ff, ii_ff, ri_ff;
   logic [LIMIT_W-1:0]       k_ff, k_in;
   logic signed [PROD_W-1:0] c_re_x, c_im_x, re_sum, im_sum;
   logic [PROD_W-1:0]        mag;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]       color_ff, color_in;
   logic                     esc_ff, esc_in;
   logic [LIMIT_W-1:0]       idx_ff, idx_in;

   jets_div_lane #(.DIVISOR(IMAGE_WIDTH)) u_col (
      .clock    (clock),
      .load     (cmd.load),
      .pixel    (pixel_column),
      .quotient (quot_col)
   );

   jets_div_lane #(.DIVISOR(IMAGE_HEIGHT)) u_row (
      .clock    (clock),
      .load     (cmd.load),
      .pixel    (pixel_row),
      .quotient (quot_row)
   );

   assign c_re_x = {{(PROD_W - Z_W){cfg.c_real[Z_W-1]}}, cfg.c_real};
   assign c_im_x = {{(PROD_W - Z_W){cfg.c_imag[Z_W-1]}}, cfg.c_imag};
   assign re_sum = ((rr_ff - ii_ff) >>> ZR_SHIFT) + c_re_x;
   assign im_sum = (ri_ff >>> ZI_SHIFT) + c_im_x;
   assign mag    = $unsigned(rr_ff) + $unsigned(ii_ff);

   always_comb begin
      zr_in = zr_ff;
      zi_in = zi_ff;
      k_in  = k_ff;
      if (cmd.seed) begin
         zr_in = map_coord(quot_col);
         zi_in = map_coord(quot_row);
         k_in  = '0;
      end else if (cmd.step) begin
         zr_in = sat_z(re_sum);
         zi_in = sat_z(im_sum);
         k_in  = k_ff + LIMIT_W'(1);
      end
   end

   assign status.hit      = (k_ff != '0) && (mag[PROD_W-1:ESC_BIT] != '0);
   assign status.at_limit = k_ff == cfg.iteration_limit;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      esc_in   = esc_ff;
      idx_in   = idx_ff;
      color_in = color_ff;
      if (cmd.publish) begin
         esc_in   = status.hit;
         idx_in   = status.hit ? k_ff - LIMIT_W'(1) : k_ff;
         color_in = '0;
         if (status.hit) begin
            if (idx_in <= cfg.first_band_limit)       color_in = cfg.first_color;
            else if (idx_in <= cfg.second_band_limit) color_in = cfg.second_color;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish)     rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      color_ff <= color_in;
      esc_ff   <= esc_in;
      idx_ff   <= idx_in;
      if (cmd.mul) begin
         rr_ff <= zr_ff * zr_ff;
         ii_ff <= zi_ff * zi_ff;
         ri_ff <= zr_ff * zi_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign pixel_color  = color_ff;
   assign did_escape   = esc_ff;
   assign escape_index = idx_ff;

   a_publish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("result not presented after publish");

   a_publish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transfer");

   a_seed_clears_count: assert property (@(posedge clock) disable iff (reset)
      cmd.seed |=> (k_ff == '0))
      else $error("iteration count not cleared on seed");

   a_step_only_live: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!status.hit && !status.at_limit))
      else $error("iteration advanced past escape or limit");

endmodule

// File: rtl/julia_escape_time_pixel.sv
// Top level of the Julia escape-time pixel evaluator with its register file.
//
//   channel   direction   handshake               payload
//   req       in          req_tvalid/req_tready   pixel_column, pixel_row
//   rsp       out         rsp_tvalid/rsp_tready   pixel_color, did_escape, escape_index
//   csr       in          csr_we                  csr_index, csr_wdata
//
// One pixel at a time: the transfer cycle scales both coordinates by a constant
// reciprocal, a seed state follows, then each pass runs multiply, then update.
// The time between transfers grows with the escape index i, or with
// iteration_limit when there is no escape; the multiply/update loop sets this.
// Synchronous reset restores the register defaults; no clearing pass.
// A stalled result waits in the output register; the next pixel is taken meanwhile
// only once the previous result has left the evaluate stage.
`timescale 1ns / 1ps

module julia_escape_time_pixel import jets_pkg::*; #(
   parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [9:0] pixel_column, [19:10] pixel_row, [23:20] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] pixel_color, [32] did_escape, [40:33] escape_index, [47:41] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type            cfg_ff, cfg_in;
   cmd_type            cmd;
   status_type         status;
   logic [COLOR_W-1:0] pixel_color;
   logic               did_escape;
   logic [LIMIT_W-1:0] escape_index;
   logic [REQ_PAD_W-1:0] req_pad_unused;

   assign req_pad_unused = req_tdata[REQ_TDATA_W-1:2*PIX_W];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_C_REAL:            cfg_in.c_real            = csr_wdata[Z_W-1:0];
            CSR_C_IMAG:            cfg_in.c_imag            = csr_wdata[Z_W-1:0];
            CSR_ITERATION_LIMIT:   cfg_in.iteration_limit   = csr_wdata[LIMIT_W-1:0];
            CSR_FIRST_BAND_LIMIT:  cfg_in.first_band_limit  = csr_wdata[LIMIT_W-1:0];
            CSR_SECOND_BAND_LIMIT: cfg_in.second_band_limit = csr_wdata[LIMIT_W-1:0];
            CSR_FIRST_COLOR:       cfg_in.first_color       = csr_wdata[COLOR_W-1:0];
            CSR_SECOND_COLOR:      cfg_in.second_color      = csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jets_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   jets_dp #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .pixel_column (req_tdata[PIX_W-1:0]),
      .pixel_row    (req_tdata[2*PIX_W-1:PIX_W]),
      .cfg          (cfg_ff),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .pixel_color  (pixel_color),
      .did_escape   (did_escape),
      .escape_index (escape_index)
   );

   assign rsp_tdata = {{RSP_PAD_W{req_pad_unused[0] & 1'b0}}, escape_index, did_escape,
                       pixel_color};

endmodule

// File: tb/julia_escape_time_pixel_tb.sv
// Self-checking testbench for the Julia escape-time pixel evaluator.
`timescale 1ns / 1ps

module julia_escape_time_pixel_tb import jets_pkg::*; ();

   localparam int     PHASES          = 16;
   localparam int     ITEMS_PER_PHASE = 108;
   localparam int     DRAIN_CYCLES    = 600;
   localparam longint WORD_MAX        = 64'sd2147483647;
   localparam longint WORD_MIN        = -64'sd2147483648;

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_color;
      logic               did_escape;
      logic [LIMIT_W-1:0] escape_index;
   } pixel_outcome_type;

   typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      csr_index_type          reg_index;
      logic [CSR_DATA_W-1:0]  value;
      logic [PIX_W-1:0]       col;
      logic [PIX_W-1:0]       row;
      logic                   typed;
      pixel_outcome_type      outcome;
   } script_step_type;

   localparam int SCRIPT_LEN = 30;
   localparam pixel_outcome_type NONE = '{32'd0, 1'b0, 8'd0};

   localparam script_step_type SCRIPT [0:SCRIPT_LEN-1] = '{
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd0, 10'd0, 1'b1, '{32'h0000_FFFF, 1'b1, 8'd0}},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd1023, 10'd1023, 1'b1, '{32'h0000_FFFF, 1'b1, 8'd0}},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd799, 10'd599, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd400, 10'd300, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd0, 10'd599, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd799, 10'd0, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd1023, 10'd0, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd512, 10'd682, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd341, 10'd341, 1'b0, NONE},
      '{ROW_WRITE, CSR_ITERATION_LIMIT, 32'd0, 10'd0, 10'd0, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd400, 10'd300, 1'b1, '{32'd0, 1'b0, 8'd0}},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd0, 10'd0, 1'b1, '{32'd0, 1'b0, 8'd0}},
      '{ROW_WRITE, CSR_ITERATION_LIMIT, 32'd255, 10'd0, 10'd0, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd400, 10'd300, 1'b0, NONE},
      '{ROW_WRITE, CSR_FIRST_BAND_LIMIT, 32'd200, 10'd0, 10'd0, 1'b0, NONE},
      '{ROW_WRITE, CSR_SECOND_BAND_LIMIT, 32'd10, 10'd0, 10'd0, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd100, 10'd100, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd420, 10'd280, 1'b0, NONE},
      '{ROW_WRITE, CSR_FIRST_BAND_LIMIT, 32'd0, 10'd0, 10'd0, 1'b0, NONE},
      '{ROW_WRITE, CSR_SECOND_BAND_LIMIT, 32'd255, 10'd0, 10'd0, 1'b0, NONE},
      '{ROW_WRITE, CSR_FIRST_COLOR, 32'hFFFF_FFFF, 10'd0, 10'd0, 1'b0, NONE},
      '{ROW_WRITE, CSR_SECOND_COLOR, 32'hA5A5_A5A5, 10'd0, 10'd0, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd0, 10'd0, 1'b1, '{32'hFFFF_FFFF, 1'b1, 8'd0}},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd600, 10'd300, 1'b0, NONE},
      '{ROW_WRITE, CSR_C_REAL, 32'h8000_0000, 10'd0, 10'd0, 1'b0, NONE},
      '{ROW_WRITE, CSR_C_IMAG, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd400, 10'd300, 1'b1, '{32'hFFFF_FFFF, 1'b1, 8'd0}},
      '{ROW_WRITE, CSR_C_REAL, 32'd0, 10'd0, 10'd0, 1'b0, NONE},
      '{ROW_WRITE, CSR_C_IMAG, 32'd0, 10'd0, 10'd0, 1'b0, NONE},
      '{ROW_PIXEL, CSR_C_REAL, 32'd0, 10'd400, 10'd300, 1'b1, '{32'd0, 1'b0, 8'd255}}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // [9:0] pixel_column, [19:10] pixel_row, [23:20] zero
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [31:0] pixel_color, [32] did_escape, [40:33] escape_index, [47:41] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   cfg_type           settings;
   pixel_outcome_type pending_pixels [$];
   bit                send_gaps_on;
   bit                rsp_stall_on;
   int                rsp_stall_left;
   int                pixels_sent;
   int                beyond_image;
   int                results_seen;
   int                escaped_seen;
   int                settings_loaded;
   int                mismatches;

   julia_escape_time_pixel u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint clamp_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   function automatic longint pixel_to_coord(logic [PIX_W-1:0] p, longint span);
      longint scaled;
      scaled = longint'({{(64-PIX_W){1'b0}}, p} << FRAC_SHIFT) / span;
      return clamp_word(scaled - (64'sd1 <<< MAP_BIAS_SHIFT));
   endfunction

   function automatic pixel_outcome_type escape_time_of(logic [PIX_W-1:0] col,
                                                        logic [PIX_W-1:0] row);
      longint            zr, zi, cr, ci, rr, ii, ri;
      logic [63:0]       mag;
      int                k;
      bit                hit;
      pixel_outcome_type o;
      zr  = pixel_to_coord(col, DEF_IMAGE_WIDTH);
      zi  = pixel_to_coord(row, DEF_IMAGE_HEIGHT);
      cr  = longint'($signed(settings.c_real));
      ci  = longint'($signed(settings.c_imag));
      hit = 1'b0;
      k   = 0;
      while (!hit && k < int'(settings.iteration_limit)) begin
         rr  = zr * zr;
         ii  = zi * zi;
         ri  = zr * zi;
         zr  = clamp_word(((rr - ii) >>> ZR_SHIFT) + cr);
         zi  = clamp_word((ri >>> ZI_SHIFT) + ci);
         mag = zr * zr + zi * zi;
         if (mag >= (64'd1 << ESC_BIT)) hit = 1'b1;
         else k++;
      end
      o.escape_index = k[LIMIT_W-1:0];
      o.did_escape   = hit;
      if (!hit) o.pixel_color = '0;
      else if (k <= int'(settings.first_band_limit)) o.pixel_color = settings.first_color;
      else if (k <= int'(settings.second_band_limit)) o.pixel_color = settings.second_color;
      else o.pixel_color = '0;
      return o;
   endfunction

   function automatic cfg_type pick_settings(int ph);
      cfg_type s;
      case (ph % 4)
         0: begin
            case ($urandom_range(0, 4))
               0: begin s.c_real = 32'hF333_3333;  s.c_imag = 32'h027E_F9DB;  end
               1: begin s.c_real = -32'sd107374182; s.c_imag = 32'sd161061274; end
               2: begin s.c_real = 32'sd76503450;   s.c_imag = 32'sd2684355;   end
               3: begin s.c_real = -32'sd224141558; s.c_imag = -32'sd62303869; end
               default: begin s.c_real = -32'sd195125733; s.c_imag = 32'sd50707458; end
            endcase
         end
         1: begin
            s.c_real = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
            s.c_imag = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
         end
         2: begin
            s.c_real = $urandom();
            s.c_imag = $urandom();
         end
         default: begin
            s.c_real = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
            s.c_imag = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
         end
      endcase
      case (ph)
         1:       s.iteration_limit = 8'd0;
         2:       s.iteration_limit = 8'd255;
         5:       s.iteration_limit = 8'd1;
         default: s.iteration_limit = LIMIT_W'($urandom_range(1, 96));
      endcase
      case (ph % 3)
         0: begin
            s.first_band_limit  = LIMIT_W'($urandom_range(0, s.iteration_limit));
            s.second_band_limit = LIMIT_W'($urandom_range(s.first_band_limit,
                                                          s.iteration_limit));
         end
         1: begin
            s.first_band_limit  = LIMIT_W'($urandom_range(0, 255));
            s.second_band_limit = LIMIT_W'($urandom_range(0, 255));
         end
         default: begin
            s.first_band_limit  = LIMIT_W'($urandom_range(0, 255));
            s.second_band_limit = LIMIT_W'($urandom_range(0, s.first_band_limit));
         end
      endcase
      case (ph)
         3:       begin s.first_color = '0;        s.second_color = '1;        end
         4:       begin s.first_color = '1;        s.second_color = '0;        end
         default: begin s.first_color = $urandom(); s.second_color = $urandom(); end
      endcase
      return s;
   endfunction

   task automatic flag_mismatch(string what, logic [RSP_TDATA_W-1:0] want,
                                logic [RSP_TDATA_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on result %0d, %s: expected %h, got %h",
                  results_seen, what, want, got);
   endtask

   // Lower valid and hold until the block has returned every result.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_C_REAL:            settings.c_real            = value;
         CSR_C_IMAG:            settings.c_imag            = value;
         CSR_ITERATION_LIMIT:   settings.iteration_limit   = value[LIMIT_W-1:0];
         CSR_FIRST_BAND_LIMIT:  settings.first_band_limit  = value[LIMIT_W-1:0];
         CSR_SECOND_BAND_LIMIT: settings.second_band_limit = value[LIMIT_W-1:0];
         CSR_FIRST_COLOR:       settings.first_color       = value;
         CSR_SECOND_COLOR:      settings.second_color      = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_settings(cfg_type s);
      write_reg(CSR_C_REAL, s.c_real);
      write_reg(CSR_C_IMAG, s.c_imag);
      write_reg(CSR_ITERATION_LIMIT, CSR_DATA_W'(s.iteration_limit));
      write_reg(CSR_FIRST_BAND_LIMIT, CSR_DATA_W'(s.first_band_limit));
      write_reg(CSR_SECOND_BAND_LIMIT, CSR_DATA_W'(s.second_band_limit));
      write_reg(CSR_FIRST_COLOR, s.first_color);
      write_reg(CSR_SECOND_COLOR, s.second_color);
      settings_loaded++;
   endtask

   task automatic maybe_pause();
      if (send_gaps_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
   endtask

   task automatic send_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row,
                             pixel_outcome_type want);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_pixels.push_back(want);
      pixels_sent++;
      if (col >= DEF_IMAGE_WIDTH || row >= DEF_IMAGE_HEIGHT) beyond_image++;
   endtask

   always @(negedge clock) begin
      if (reset || !rsp_stall_on) begin
         rsp_tready <= 1'b1;
      end else if (rsp_stall_left != 0) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pixel_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_pixels.size() == 0) begin
            flag_mismatch("result with nothing pending", '0, rsp_tdata);
         end else begin
            want = pending_pixels.pop_front();
            if (want.did_escape) escaped_seen++;
            if (rsp_tdata[COLOR_W-1:0] !== want.pixel_color)
               flag_mismatch("pixel_color", RSP_TDATA_W'(want.pixel_color),
                             RSP_TDATA_W'(rsp_tdata[COLOR_W-1:0]));
            if (rsp_tdata[COLOR_W] !== want.did_escape)
               flag_mismatch("did_escape", RSP_TDATA_W'(want.did_escape),
                             RSP_TDATA_W'(rsp_tdata[COLOR_W]));
            if (rsp_tdata[COLOR_W+LIMIT_W:COLOR_W+1] !== want.escape_index)
               flag_mismatch("escape_index", RSP_TDATA_W'(want.escape_index),
                             RSP_TDATA_W'(rsp_tdata[COLOR_W+LIMIT_W:COLOR_W+1]));
            if (rsp_tdata[RSP_TDATA_W-1:COLOR_W+LIMIT_W+1] !== '0)
               flag_mismatch("padding", '0,
                             RSP_TDATA_W'(rsp_tdata[RSP_TDATA_W-1:COLOR_W+LIMIT_W+1]));
         end
      end
   end

   initial begin
      #60_000_000;
      $display("julia_escape_time_pixel_tb failed");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      rsp_stall_left = 0;
      csr_we         = 1'b0;
      csr_index      = CSR_C_REAL;
      csr_wdata      = '0;
      settings       = CFG_RESET;
      send_gaps_on   = 1'b1;
      rsp_stall_on   = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         script_step_type st;
         st = SCRIPT[i];
         if (st.kind == ROW_WRITE) begin
            settle();
            write_reg(st.reg_index, st.value);
         end else begin
            maybe_pause();
            send_pixel(st.col, st.row, st.typed ? st.outcome : escape_time_of(st.col, st.row));
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         cfg_type s;
         settle();
         s = pick_settings(ph);
         load_settings(s);
         send_gaps_on = (ph != PHASES - 1) && (ph % 5 != 4);
         rsp_stall_on = (ph != PHASES - 1) && (ph % 5 != 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            logic [PIX_W-1:0] col;
            logic [PIX_W-1:0] row;
            if (send_gaps_on && $urandom_range(0, 39) == 0) settle();
            maybe_pause();
            if ($urandom_range(0, 4) == 0) begin
               col = PIX_W'($urandom_range(0, 1023));
               row = PIX_W'($urandom_range(0, 1023));
            end else begin
               col = PIX_W'($urandom_range(0, DEF_IMAGE_WIDTH - 1));
               row = PIX_W'($urandom_range(0, DEF_IMAGE_HEIGHT - 1));
            end
            send_pixel(col, row, escape_time_of(col, row));
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d pixels, %0d of them outside the image, over %0d register sets",
               pixels_sent, beyond_image, settings_loaded);
      $display("checked %0d results: %0d escaped, %0d stayed bounded, %0d mismatches",
               results_seen, escaped_seen, results_seen - escaped_seen, mismatches);
      if (mismatches == 0) begin
         $display("julia_escape_time_pixel_tb passed");
      end else begin
         $display("julia_escape_time_pixel_tb failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/jets_pkg.sv
rtl/jets_div_lane.sv
rtl/jets_ctrl.sv
rtl/jets_dp.sv
rtl/julia_escape_time_pixel.sv
tb/julia_escape_time_pixel_tb.sv
